### sv/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg: shared types, constants and helpers for the vector alu
// Element format, mode codes, rounding and saturation; every file draws on the package.
// ----------------------------------------------------------------------------
`default_nettype none

package vfa_pkg;

	localparam int EW     = 32;          // element width
	localparam int FB     = 16;          // fraction bits
	localparam int WW     = 2 * EW + 2;  // wide working width
	localparam int NUM_W  = EW + FB;     // divider numerator / quotient width
	localparam int DEN_W  = EW + 1;      // divider denominator width
	localparam int RAD_W  = 2 * EW;      // square root radicand width
	localparam int ROOT_W = EW + 1;      // rounded root width

	typedef logic signed [EW-1:0]   el_t;
	typedef logic signed [2*EW-1:0] prod_t;
	typedef logic signed [WW-1:0]   wide_t;

	// operation codes
	localparam logic [3:0] MODE_LOAD   = 4'd0;
	localparam logic [3:0] MODE_ADD    = 4'd1;
	localparam logic [3:0] MODE_SUB    = 4'd2;
	localparam logic [3:0] MODE_MUL    = 4'd3;
	localparam logic [3:0] MODE_SCALE  = 4'd4;
	localparam logic [3:0] MODE_DIV    = 4'd5;
	localparam logic [3:0] MODE_DIVS   = 4'd6;
	localparam logic [3:0] MODE_NEG    = 4'd7;
	localparam logic [3:0] MODE_NORM   = 4'd8;
	localparam logic [3:0] MODE_PROJ   = 4'd9;
	localparam logic [3:0] MODE_DOT    = 4'd10;
	localparam logic [3:0] MODE_CROSS  = 4'd11;
	localparam logic [3:0] MODE_EQ     = 4'd12;
	localparam logic [3:0] MODE_LEN    = 4'd13;
	localparam logic [3:0] MODE_SQLEN  = 4'd14;

	localparam wide_t EL_MAX_W = (wide_t'(1) <<< (EW - 1)) - wide_t'(1);
	localparam wide_t EL_MIN_W = -(wide_t'(1) <<< (EW - 1));
	localparam wide_t HALF_W   = wide_t'(1) <<< (FB - 1);
	localparam el_t   EL_ONE   = el_t'(1) <<< FB;

	// drop fraction bits, round half away from zero
	function automatic wide_t rnd_fb(input wide_t p);
		wide_t m;
		wide_t r;
		m = p[WW-1] ? -p : p;
		r = (m + HALF_W) >>> FB;
		return p[WW-1] ? -r : r;
	endfunction

	// clamp to the element range
	function automatic el_t sat_el(input wide_t v);
		el_t r;
		if (v > EL_MAX_W) begin
			r = EL_MAX_W[EW-1:0];
		end else if (v < EL_MIN_W) begin
			r = EL_MIN_W[EW-1:0];
		end else begin
			r = v[EW-1:0];
		end
		return r;
	endfunction

	// magnitude of an element, one bit wider
	function automatic logic [DEN_W-1:0] mag_el(input el_t v);
		logic signed [DEN_W-1:0] e;
		e = {v[EW-1], v};
		return v[EW-1] ? unsigned'(-e) : unsigned'(e);
	endfunction

endpackage

`default_nettype wire

### sv/vfa_req_if.sv
// ----------------------------------------------------------------------------
// vfa_req_if: operation channel
// Carries the mode and the operand vectors b and c.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfa_req_if;
	logic            valid;
	logic            ready;
	logic [3:0]      mode;
	vfa_pkg::el_t    vec_b_x;
	vfa_pkg::el_t    vec_b_y;
	vfa_pkg::el_t    vec_b_z;
	vfa_pkg::el_t    vec_b_w;
	vfa_pkg::el_t    vec_c_x;
	vfa_pkg::el_t    vec_c_y;
	vfa_pkg::el_t    vec_c_z;
	vfa_pkg::el_t    vec_c_w;

	modport source (
		output valid, mode, vec_b_x, vec_b_y, vec_b_z, vec_b_w,
		vec_c_x, vec_c_y, vec_c_z, vec_c_w,
		input  ready
	);
	modport sink (
		input  valid, mode, vec_b_x, vec_b_y, vec_b_z, vec_b_w,
		vec_c_x, vec_c_y, vec_c_z, vec_c_w,
		output ready
	);
endinterface

`default_nettype wire

### sv/vfa_rsp_if.sv
// ----------------------------------------------------------------------------
// vfa_rsp_if: result channel
// Carries the result vector, the scalar and the status bits.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfa_rsp_if;
	logic          valid;
	logic          ready;
	vfa_pkg::el_t  res_x;
	vfa_pkg::el_t  res_y;
	vfa_pkg::el_t  res_z;
	vfa_pkg::el_t  res_w;
	vfa_pkg::el_t  scalar_out;
	logic          is_equal;
	logic          fault;

	modport source (
		output valid, res_x, res_y, res_z, res_w, scalar_out, is_equal, fault,
		input  ready
	);
	modport sink (
		input  valid, res_x, res_y, res_z, res_w, scalar_out, is_equal, fault,
		output ready
	);
endinterface

`default_nettype wire

### sv/vfa_div.sv
// ----------------------------------------------------------------------------
// vfa_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [vfa_pkg::NUM_W-1:0]  num,
	input  wire logic [vfa_pkg::DEN_W-1:0]  den,
	output logic                            done,
	output logic [vfa_pkg::NUM_W-1:0]       quo
);
	import vfa_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				den_q  <= den;
				quo_q  <= num;
			end else if (busy_q) begin
				rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

`default_nettype wire

### sv/vfa_sqrt.sv
// ----------------------------------------------------------------------------
// vfa_sqrt: serial square root, rounded to nearest
// Digit-by-digit root, two radicand bits per cycle, then a nearest correction.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [vfa_pkg::RAD_W-1:0]  rad,
	output logic                            done,
	output logic [vfa_pkg::ROOT_W-1:0]      root
);
	import vfa_pkg::*;

	localparam int HR_W  = RAD_W / 2;
	localparam int REM_W = HR_W + 2;
	localparam int CNT_W = $clog2(HR_W);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [HR_W-1:0]  root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             ge;

	// bring in the next two radicand bits and test the next root bit
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rad_q  <= rad;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rem_q  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
				root_q <= {root_q[HR_W-2:0], ge};
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(HR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// round up when the remainder passes the floor root
	assign root = {1'b0, root_q} + ROOT_W'(rem_q > {2'b00, root_q});
	assign done = done_q;
endmodule

`default_nettype wire

### sv/vec4_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu: four-element Q16.16 vector alu with accumulator
// Sequencer around one shared multiplier, a serial divider and a serial root.
// ----------------------------------------------------------------------------
// The block holds a four-element accumulator (zero after reset) and runs one
// operation per request beat, answering with exactly one response beat. It
// takes one request at a time. Load, add, sub, neg, eq and the unused code
// are done in the accept cycle and go on to the response register; mul,
// scale, dot and sqlen issue and then consume one product per element on the
// one multiplier; cross takes nine multiplies per output element; len and
// norm sum the squares, then run the 32-step root, and norm then four 48-step
// divisions; div and divscalar run the 48-step divider per element, proj for
// three elements. A response held by the sink keeps the next result waiting
// in S_DONE. A new request is taken while the previous response still
// waits.
`default_nettype none

module vec4_fixed_point_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	vfa_req_if.sink   req,
	vfa_rsp_if.source rsp
);
	import vfa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_SQRT = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t      state_q;
	logic [3:0]  mode_q;
	logic [1:0]  idx_q;
	logic [3:0]  step_q;
	logic        ph_q;
	el_t         acc_q [4];
	el_t         b_q   [4];
	el_t         c_q   [4];
	el_t         r_q   [4];
	el_t         m_q   [3];
	wide_t       sum_q;
	el_t         scal_q;
	logic        eq_q;
	logic        flt_q;
	logic        upd_q;
	logic [ROOT_W-1:0] root_q;
	prod_t       prod_q;

	logic        out_valid_q;
	el_t         out_r_q [4];
	el_t         out_s_q;
	logic        out_eq_q;
	logic        out_flt_q;

	el_t         in_b [4];
	el_t         in_c [4];
	el_t         mul_a;
	el_t         mul_b;
	wide_t       prod_w;
	wide_t       prod_r;
	el_t         cr_v;
	logic [1:0]  ci;
	logic [1:0]  cj;
	logic [1:0]  ck;
	logic        sq_mode;

	logic [DEN_W-1:0] den_sel;
	logic             den_neg;
	logic [NUM_W-1:0] div_num;
	logic             div_start;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;
	wide_t            quo_s;
	logic             div_last;

	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	wide_t             sq_nx;
	logic [RAD_W-1:0]  sq_in;
	logic              out_free;

	assign in_b = '{req.vec_b_x, req.vec_b_y, req.vec_b_z, req.vec_b_w};
	assign in_c = '{req.vec_c_x, req.vec_c_y, req.vec_c_z, req.vec_c_w};

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign sq_mode   = (mode_q == MODE_NORM) || (mode_q == MODE_LEN) ||
	                   (mode_q == MODE_SQLEN);

	// cross: row picks for the determinant of output element idx
	assign ci = (idx_q == 2'd0) ? 2'd1 : 2'd0;
	assign cj = (idx_q <= 2'd1) ? 2'd2 : 2'd1;
	assign ck = (idx_q == 2'd3) ? 2'd2 : 2'd3;

	// multiplier operand select
	always_comb begin
		mul_a = acc_q[idx_q];
		mul_b = b_q[idx_q];
		if (mode_q == MODE_SCALE) begin
			mul_b = b_q[0];
		end else if (sq_mode) begin
			mul_b = acc_q[idx_q];
		end else if (mode_q == MODE_CROSS) begin
			case (step_q)
				4'd0: begin mul_a = b_q[cj];   mul_b = c_q[ck];   end
				4'd1: begin mul_a = c_q[cj];   mul_b = b_q[ck];   end
				4'd2: begin mul_a = c_q[cj];   mul_b = acc_q[ck]; end
				4'd3: begin mul_a = acc_q[cj]; mul_b = c_q[ck];   end
				4'd4: begin mul_a = acc_q[cj]; mul_b = b_q[ck];   end
				4'd5: begin mul_a = b_q[cj];   mul_b = acc_q[ck]; end
				4'd6: begin mul_a = acc_q[ci]; mul_b = m_q[0];    end
				4'd7: begin mul_a = b_q[ci];   mul_b = m_q[1];    end
				default: begin mul_a = c_q[ci]; mul_b = m_q[2];   end
			endcase
		end
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= prod_t'(mul_a) * prod_t'(mul_b);
	end

	assign prod_w = wide_t'(prod_q);
	assign prod_r = rnd_fb(prod_w);
	assign cr_v   = sat_el(sum_q + prod_r);

	// sum of squares, clamped to the radicand width
	assign sq_nx = sum_q + prod_w;
	assign sq_in = (sq_nx[WW-1:RAD_W] != '0) ? '1 : sq_nx[RAD_W-1:0];
	assign sqrt_start = (state_q == S_MUL) && ph_q && (idx_q == 2'd3) &&
	                    ((mode_q == MODE_NORM) || (mode_q == MODE_LEN));

	// divisor select and rounded numerator
	always_comb begin
		den_sel = mag_el(b_q[idx_q]);
		den_neg = b_q[idx_q][EW-1];
		if (mode_q == MODE_DIVS) begin
			den_sel = mag_el(b_q[0]);
			den_neg = b_q[0][EW-1];
		end else if (mode_q == MODE_PROJ) begin
			den_sel = mag_el(acc_q[3]);
			den_neg = acc_q[3][EW-1];
		end else if (mode_q == MODE_NORM) begin
			den_sel = root_q;
			den_neg = 1'b0;
		end
	end

	assign div_num   = (NUM_W'(mag_el(acc_q[idx_q])) << FB) + NUM_W'(den_sel >> 1);
	assign div_start = (state_q == S_DIV) && !ph_q;
	assign quo_s     = (acc_q[idx_q][EW-1] ^ den_neg) ? -wide_t'(div_quo) :
	                   wide_t'(div_quo);
	assign div_last  = (mode_q == MODE_PROJ) ? (idx_q == 2'd2) : (idx_q == 2'd3);

	vfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_sel),
		.done   (div_done),
		.quo    (div_quo)
	);

	vfa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sq_in),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			step_q      <= '0;
			ph_q        <= 1'b0;
			for (int n = 0; n < 4; n++) begin
				acc_q[n] <= '0;
			end
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q <= req.mode;
						b_q    <= in_b;
						c_q    <= in_c;
						r_q    <= acc_q;
						sum_q  <= '0;
						scal_q <= '0;
						eq_q   <= 1'b0;
						flt_q  <= 1'b0;
						upd_q  <= 1'b0;
						idx_q  <= '0;
						step_q <= '0;
						ph_q   <= 1'b0;
						state_q <= S_DONE;
						case (req.mode)
							MODE_LOAD: begin
								r_q   <= in_b;
								upd_q <= 1'b1;
							end
							MODE_ADD, MODE_SUB, MODE_NEG: begin
								for (int n = 0; n < 4; n++) begin
									if (req.mode == MODE_ADD) begin
										r_q[n] <= sat_el(wide_t'(acc_q[n]) + wide_t'(in_b[n]));
									end else if (req.mode == MODE_SUB) begin
										r_q[n] <= sat_el(wide_t'(acc_q[n]) - wide_t'(in_b[n]));
									end else begin
										r_q[n] <= sat_el(-wide_t'(acc_q[n]));
									end
								end
								upd_q <= 1'b1;
							end
							MODE_EQ: begin
								eq_q <= (acc_q[0] == in_b[0]) && (acc_q[1] == in_b[1]) &&
								        (acc_q[2] == in_b[2]) && (acc_q[3] == in_b[3]);
							end
							MODE_MUL, MODE_SCALE, MODE_DOT, MODE_SQLEN, MODE_NORM,
							MODE_LEN, MODE_CROSS: begin
								state_q <= S_MUL;
							end
							MODE_DIV: begin
								if ((in_b[0] == '0) || (in_b[1] == '0) ||
								    (in_b[2] == '0) || (in_b[3] == '0)) begin
									flt_q <= 1'b1;
								end else begin
									state_q <= S_DIV;
								end
							end
							MODE_DIVS: begin
								if (in_b[0] == '0) begin
									flt_q <= 1'b1;
								end else begin
									state_q <= S_DIV;
								end
							end
							MODE_PROJ: begin
								if (acc_q[3] == '0) begin
									flt_q <= 1'b1;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: begin
							end
						endcase
					end
				end

				// each product: issue, then consume
				S_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (mode_q == MODE_CROSS) begin
							case (step_q)
								4'd0, 4'd2, 4'd4: begin
									sum_q  <= prod_w;
									step_q <= step_q + 4'd1;
								end
								4'd1: begin
									m_q[0] <= sat_el(rnd_fb(sum_q - prod_w));
									step_q <= step_q + 4'd1;
								end
								4'd3: begin
									m_q[1] <= sat_el(rnd_fb(sum_q - prod_w));
									step_q <= step_q + 4'd1;
								end
								4'd5: begin
									m_q[2] <= sat_el(rnd_fb(sum_q - prod_w));
									step_q <= step_q + 4'd1;
								end
								4'd6: begin
									sum_q  <= prod_r;
									step_q <= step_q + 4'd1;
								end
								4'd7: begin
									sum_q  <= sum_q + prod_r;
									step_q <= step_q + 4'd1;
								end
								default: begin
									r_q[idx_q] <= idx_q[0] ? sat_el(-wide_t'(cr_v)) : cr_v;
									step_q     <= '0;
									idx_q      <= idx_q + 2'd1;
									if (idx_q == 2'd3) begin
										state_q <= S_DONE;
									end
								end
							endcase
						end else begin
							idx_q <= idx_q + 2'd1;
							if ((mode_q == MODE_MUL) || (mode_q == MODE_SCALE)) begin
								r_q[idx_q] <= sat_el(prod_r);
								upd_q      <= 1'b1;
							end else if ((mode_q == MODE_NORM) || (mode_q == MODE_LEN)) begin
								sum_q <= sq_nx;
							end else begin
								sum_q  <= sum_q + prod_r;
								scal_q <= sat_el(sum_q + prod_r);
							end
							if (idx_q == 2'd3) begin
								state_q <= ((mode_q == MODE_NORM) || (mode_q == MODE_LEN)) ?
								           S_SQRT : S_DONE;
							end
						end
					end
				end

				// wait for the rounded length
				S_SQRT: begin
					if (sqrt_done) begin
						root_q <= sqrt_root;
						idx_q  <= '0;
						ph_q   <= 1'b0;
						if (mode_q == MODE_LEN) begin
							scal_q  <= sat_el(wide_t'(sqrt_root));
							state_q <= S_DONE;
						end else if (sqrt_root == '0) begin
							flt_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end

				// one division per element
				S_DIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (div_done) begin
						ph_q       <= 1'b0;
						r_q[idx_q] <= sat_el(quo_s);
						idx_q      <= idx_q + 2'd1;
						if (div_last) begin
							state_q <= S_DONE;
							if (mode_q == MODE_PROJ) begin
								r_q[3] <= EL_ONE;
							end else begin
								upd_q <= 1'b1;
							end
						end
					end
				end

				// hand the result to the output register once it is free, and commit the accumulator
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_r_q     <= r_q;
						out_s_q     <= scal_q;
						out_eq_q    <= eq_q;
						out_flt_q   <= flt_q;
						if (upd_q) begin
							acc_q <= r_q;
						end
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.res_x      = out_r_q[0];
	assign rsp.res_y      = out_r_q[1];
	assign rsp.res_z      = out_r_q[2];
	assign rsp.res_w      = out_r_q[3];
	assign rsp.scalar_out = out_s_q;
	assign rsp.is_equal   = out_eq_q;
	assign rsp.fault      = out_flt_q;
endmodule

`default_nettype wire

### tb/sv/tb_vec4_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vec4_fixed_point_alu: self-checking bench for the vector alu
// A clocked driver feeds operation beats from a queue of pending operations
// with random gaps. An accumulator model predicts each response at acceptance,
// and a clocked monitor with random and long stalls compares it field by field.
// ----------------------------------------------------------------------------

module tb_vec4_fixed_point_alu;
	import vfa_pkg::*;

	typedef logic signed [127:0] big_t;

	typedef struct {
		logic [3:0] mode;
		el_t        b [4];
		el_t        c [4];
		bit         b_is_acc;   // b taken from the accumulator when driven
	} op_t;

	typedef struct {
		el_t  res [4];
		el_t  scalar;
		logic eq;
		logic flt;
	} alu_rsp_t;

	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 600;

	logic clk;
	logic arst_n;

	vfa_req_if req ();
	vfa_rsp_if rsp ();

	vec4_fixed_point_alu DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	op_t      pending_ops [$];
	alu_rsp_t expected_rsps [$];
	big_t     model_acc [4];
	int       err_cnt;
	int       rsp_cnt;
	int       idle_cycles;
	bit       stim_done;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ---------------- fixed-point model ----------------
	function automatic big_t clamp_el(big_t v);
		if (v > big_t'(EL_MAX_W)) return big_t'(EL_MAX_W);
		if (v < big_t'(EL_MIN_W)) return big_t'(EL_MIN_W);
		return v;
	endfunction

	function automatic big_t abs_big(big_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic big_t round_frac(big_t p);
		big_t m;
		m = (abs_big(p) + (big_t'(1) <<< (FB - 1))) >>> FB;
		return p < 0 ? -m : m;
	endfunction

	function automatic big_t qmul(big_t x, big_t y);
		return round_frac(x * y);
	endfunction

	function automatic big_t qdiv(big_t x, big_t d);
		big_t n;
		big_t dm;
		big_t q;
		n = abs_big(x) <<< FB;
		dm = abs_big(d);
		q = (n + dm / 2) / dm;
		if ((x < 0) != (d < 0)) q = -q;
		return clamp_el(q);
	endfunction

	function automatic big_t sum_sq(big_t u [4]);
		big_t s;
		s = 0;
		for (int i = 0; i < 4; i++) s += u[i] * u[i];
		if (s > big_t'(64'hFFFF_FFFF_FFFF_FFFF)) s = big_t'(64'hFFFF_FFFF_FFFF_FFFF);
		return s;
	endfunction

	// integer square root, rounded to nearest
	function automatic big_t root_near(big_t n_in);
		longint unsigned n;
		longint unsigned r;
		longint unsigned bt;
		longint unsigned x;
		n = n_in[63:0];
		r = 0;
		bt = 64'd1 << 62;
		x = n;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		if (n - r * r > r) r++;
		return big_t'(r);
	endfunction

	function automatic big_t dot_sum(big_t u [4], big_t v [4]);
		big_t s;
		s = 0;
		for (int i = 0; i < 4; i++) s += qmul(u[i], v[i]);
		return clamp_el(s);
	endfunction

	function automatic big_t minor(big_t p, big_t q, big_t r, big_t s);
		return clamp_el(round_frac(p * q - r * s));
	endfunction

	function automatic big_t det_3(big_t a [4], big_t b [4], big_t c [4],
			int i, int j, int k);
		big_t m0;
		big_t m1;
		big_t m2;
		m0 = minor(b[j], c[k], c[j], b[k]);
		m1 = minor(c[j], a[k], a[j], c[k]);
		m2 = minor(a[j], b[k], b[j], a[k]);
		return clamp_el(qmul(a[i], m0) + qmul(b[i], m1) + qmul(c[i], m2));
	endfunction

	// next accumulator and response for one accepted operation
	function automatic alu_rsp_t alu_model(op_t op);
		alu_rsp_t r;
		big_t b [4];
		big_t c [4];
		big_t nv [4];
		big_t rv [4];
		big_t sc;
		big_t len;
		bit upd;
		bit flt;
		bit eq;
		for (int i = 0; i < 4; i++) begin
			b[i] = big_t'(op.b[i]);
			c[i] = big_t'(op.c[i]);
			nv[i] = model_acc[i];
			rv[i] = model_acc[i];
		end
		sc = 0;
		upd = 0;
		flt = 0;
		eq = 0;
		case (op.mode)
			MODE_LOAD: begin
				nv = b;
				upd = 1;
			end
			MODE_ADD: begin
				for (int i = 0; i < 4; i++) nv[i] = clamp_el(model_acc[i] + b[i]);
				upd = 1;
			end
			MODE_SUB: begin
				for (int i = 0; i < 4; i++) nv[i] = clamp_el(model_acc[i] - b[i]);
				upd = 1;
			end
			MODE_MUL: begin
				for (int i = 0; i < 4; i++) nv[i] = clamp_el(qmul(model_acc[i], b[i]));
				upd = 1;
			end
			MODE_SCALE: begin
				for (int i = 0; i < 4; i++) nv[i] = clamp_el(qmul(model_acc[i], b[0]));
				upd = 1;
			end
			MODE_DIV: begin
				if (b[0] == 0 || b[1] == 0 || b[2] == 0 || b[3] == 0) begin
					flt = 1;
				end else begin
					for (int i = 0; i < 4; i++) nv[i] = qdiv(model_acc[i], b[i]);
					upd = 1;
				end
			end
			MODE_DIVS: begin
				if (b[0] == 0) begin
					flt = 1;
				end else begin
					for (int i = 0; i < 4; i++) nv[i] = qdiv(model_acc[i], b[0]);
					upd = 1;
				end
			end
			MODE_NEG: begin
				for (int i = 0; i < 4; i++) nv[i] = clamp_el(-model_acc[i]);
				upd = 1;
			end
			MODE_NORM: begin
				len = root_near(sum_sq(model_acc));
				if (len == 0) begin
					flt = 1;
				end else begin
					for (int i = 0; i < 4; i++) nv[i] = qdiv(model_acc[i], len);
					upd = 1;
				end
			end
			MODE_PROJ: begin
				if (model_acc[3] == 0) begin
					flt = 1;
				end else begin
					for (int i = 0; i < 3; i++) rv[i] = qdiv(model_acc[i], model_acc[3]);
					rv[3] = big_t'(1) <<< FB;
				end
			end
			MODE_DOT:   sc = dot_sum(model_acc, b);
			MODE_CROSS: begin
				rv[0] = det_3(model_acc, b, c, 1, 2, 3);
				rv[1] = clamp_el(-det_3(model_acc, b, c, 0, 2, 3));
				rv[2] = det_3(model_acc, b, c, 0, 1, 3);
				rv[3] = clamp_el(-det_3(model_acc, b, c, 0, 1, 2));
			end
			MODE_EQ: eq = (model_acc[0] == b[0]) && (model_acc[1] == b[1]) &&
				(model_acc[2] == b[2]) && (model_acc[3] == b[3]);
			MODE_LEN:   sc = clamp_el(root_near(sum_sq(model_acc)));
			MODE_SQLEN: sc = dot_sum(model_acc, model_acc);
			default: ;
		endcase
		if (upd) begin
			model_acc = nv;
			rv = nv;
		end
		for (int i = 0; i < 4; i++) r.res[i] = rv[i][EW-1:0];
		r.scalar = sc[EW-1:0];
		r.eq = eq;
		r.flt = flt;
		return r;
	endfunction

	// ---------------- stimulus ----------------
	function automatic el_t rand_el();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return el_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		if (sel < 55) return el_t'(0);
		if (sel < 60) return EL_MAX_W[EW-1:0];
		if (sel < 65) return EL_MIN_W[EW-1:0];
		if (sel < 70) return $urandom_range(0, 1) ? EL_ONE : -EL_ONE;
		if (sel < 80) return el_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		return el_t'($urandom);
	endfunction

	function automatic op_t make_op(logic [3:0] m, el_t bx, el_t by, el_t bz, el_t bw);
		op_t op;
		op.mode = m;
		op.b[0] = bx;
		op.b[1] = by;
		op.b[2] = bz;
		op.b[3] = bw;
		for (int i = 0; i < 4; i++) op.c[i] = rand_el();
		op.b_is_acc = 0;
		return op;
	endfunction

	function automatic op_t rand_op();
		op_t op;
		int sel;
		op = make_op(4'd0, rand_el(), rand_el(), rand_el(), rand_el());
		sel = $urandom_range(0, 99);
		if (sel < 20) op.mode = MODE_LOAD;
		else op.mode = 4'($urandom_range(1, 15));
		// nonzero divisors most of the time
		if (op.mode inside {MODE_DIV, MODE_DIVS} && $urandom_range(0, 9) != 0) begin
			for (int i = 0; i < 4; i++) if (op.b[i] == 0) op.b[i] = EL_ONE;
		end
		if (op.mode == MODE_EQ && $urandom_range(0, 1)) op.b_is_acc = 1;
		return op;
	endfunction

	// ---------------- driver ----------------
	op_t cur_op;
	int  send_gap;

	always @(posedge clk or negedge arst_n) begin
		logic nxt_valid;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= '0;
			req.vec_b_x <= '0;
			req.vec_b_y <= '0;
			req.vec_b_z <= '0;
			req.vec_b_w <= '0;
			req.vec_c_x <= '0;
			req.vec_c_y <= '0;
			req.vec_c_z <= '0;
			req.vec_c_w <= '0;
			send_gap = 0;
			for (int i = 0; i < 4; i++) model_acc[i] = 0;
		end else begin
			nxt_valid = req.valid;
			if (req.valid && req.ready) begin
				expected_rsps.push_back(alu_model(cur_op));
				nxt_valid = 1'b0;
				send_gap = $urandom_range(0, 14);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ops.size() > 0) begin
					cur_op = pending_ops.pop_front();
					if (cur_op.b_is_acc) begin
						for (int i = 0; i < 4; i++) cur_op.b[i] = model_acc[i][EW-1:0];
					end
					req.mode <= cur_op.mode;
					req.vec_b_x <= cur_op.b[0];
					req.vec_b_y <= cur_op.b[1];
					req.vec_b_z <= cur_op.b[2];
					req.vec_b_w <= cur_op.b[3];
					req.vec_c_x <= cur_op.c[0];
					req.vec_c_y <= cur_op.c[1];
					req.vec_c_z <= cur_op.c[2];
					req.vec_c_w <= cur_op.c[3];
					nxt_valid = 1'b1;
				end
			end
			req.valid <= nxt_valid;
		end
	end

	// ---------------- monitor ----------------
	int recv_wait;
	int long_hold;

	always @(posedge clk or negedge arst_n) begin
		alu_rsp_t exp_r;
		el_t got [4];
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_wait = 0;
			long_hold = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_cnt++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response res=%h %h %h %h", $time,
						rsp.res_x, rsp.res_y, rsp.res_z, rsp.res_w);
					err_cnt++;
				end else begin
					exp_r = expected_rsps.pop_front();
					got[0] = rsp.res_x;
					got[1] = rsp.res_y;
					got[2] = rsp.res_z;
					got[3] = rsp.res_w;
					for (int i = 0; i < 4; i++) begin
						if (got[i] !== exp_r.res[i]) begin
							$display("%0t: res[%0d] expected %h actual %h", $time, i,
								exp_r.res[i], got[i]);
							err_cnt++;
						end
					end
					if (rsp.scalar_out !== exp_r.scalar) begin
						$display("%0t: scalar_out expected %h actual %h", $time,
							exp_r.scalar, rsp.scalar_out);
						err_cnt++;
					end
					if (rsp.is_equal !== exp_r.eq) begin
						$display("%0t: is_equal expected %b actual %b", $time,
							exp_r.eq, rsp.is_equal);
						err_cnt++;
					end
					if (rsp.fault !== exp_r.flt) begin
						$display("%0t: fault expected %b actual %b", $time,
							exp_r.flt, rsp.fault);
						err_cnt++;
					end
				end
				recv_wait = $urandom_range(0, 14);
				if ($urandom_range(0, 3) == 0) recv_wait = 0;
				// long stall so the block backs up and holds off new operations
				if (rsp_cnt == 300 || rsp_cnt == 1000) long_hold = LONG_HOLD;
			end
			if (long_hold > 0) begin
				long_hold--;
				rsp.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog on beats accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		el_t mx;
		el_t mn;
		arst_n = 1'b0;
		err_cnt = 0;
		rsp_cnt = 0;
		idle_cycles = 0;
		stim_done = 0;
		mx = EL_MAX_W[EW-1:0];
		mn = EL_MIN_W[EW-1:0];

		// directed corners
		pending_ops.push_back(make_op(MODE_NORM, 0, 0, 0, 0));      // zero-length normalize
		pending_ops.push_back(make_op(MODE_PROJ, 0, 0, 0, 0));      // zero w
		pending_ops.push_back(make_op(MODE_LOAD, mx, mn, EL_ONE, -EL_ONE));
		pending_ops.push_back(make_op(MODE_ADD, mx, mn, mx, mn));
		pending_ops.push_back(make_op(MODE_SUB, mn, mx, mn, mx));
		pending_ops.push_back(make_op(MODE_NEG, 0, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_LOAD, mn, mn, mn, mn));
		pending_ops.push_back(make_op(MODE_NEG, 0, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_SQLEN, 0, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_LEN, 0, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_LOAD, 32'h0003_8000, -32'sh0001_4000,
			32'h0000_8000, 32'h0002_0000));
		pending_ops.push_back(make_op(MODE_MUL, mx, mn, 32'h0000_0001, -EL_ONE));
		pending_ops.push_back(make_op(MODE_LOAD, 32'h0003_8000, -32'sh0001_4000,
			32'h0000_8000, 32'h0002_0000));
		pending_ops.push_back(make_op(MODE_SCALE, 32'h0000_C000, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_DIV, EL_ONE, 0, EL_ONE, EL_ONE));   // zero divisor
		pending_ops.push_back(make_op(MODE_DIV, 32'h0000_0003, mn, -EL_ONE, 32'h0000_4000));
		pending_ops.push_back(make_op(MODE_DIVS, 0, EL_ONE, 0, 0));            // zero scalar
		pending_ops.push_back(make_op(MODE_DIVS, -32'sh0000_3000, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_NORM, 0, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_PROJ, 0, 0, 0, 0));
		pending_ops.push_back(make_op(MODE_DOT, mx, mn, mx, mn));
		pending_ops.push_back(make_op(MODE_CROSS, mx, mn, EL_ONE, 0));
		pending_ops.push_back(make_op(MODE_EQ, 0, 0, 0, 0));
		pending_ops[$].b_is_acc = 1;
		pending_ops.push_back(make_op(MODE_EQ, 0, 0, 0, 0));
		pending_ops.push_back(make_op(4'd15, mx, mn, mx, mn));                 // unused code

		// random operations
		for (int n = 0; n < 1500; n++) pending_ops.push_back(rand_op());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && !req.valid && expected_rsps.size() == 0);
		stim_done = 1;
		repeat (300) @(posedge clk);
		if (err_cnt == 0 && expected_rsps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
sv/vfa_pkg.sv
sv/vfa_req_if.sv
sv/vfa_rsp_if.sv
sv/vfa_div.sv
sv/vfa_sqrt.sv
sv/vec4_fixed_point_alu.sv
tb/sv/tb_vec4_fixed_point_alu.sv
